/* rtl/servo_bus_frame_builder_assert.svh */
// assertion macros shared by the servo bus frame builder
`ifndef SERVO_BUS_FRAME_BUILDER_ASSERT_SVH
`define SERVO_BUS_FRAME_BUILDER_ASSERT_SVH

// same-cycle implication, checked out of reset
`define SBFB_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define SBFB_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/sbfb_pkg.sv */
// types, constants and slot codes of the servo bus frame builder
package sbfb_pkg;

    // frame layout
    localparam logic [7:0] HDR_BYTE     = 8'h55;
    localparam int         LEN_BASE     = 3;
    localparam int         PARAM_INPUTS = 4;
    localparam int         MAX_PARAMS_DEF = 4;
    localparam int         MAX_FRAME    = 10;
    localparam int         IDX_W        = $clog2(MAX_FRAME);
    localparam int         PSEL_W       = $clog2(PARAM_INPUTS);

    // depth of the queue between front and back
    localparam int         QUEUE_DEPTH  = 2;

    // byte slots of a frame
    localparam logic [IDX_W-1:0] SLOT_HDR0  = IDX_W'(0);
    localparam logic [IDX_W-1:0] SLOT_HDR1  = IDX_W'(1);
    localparam logic [IDX_W-1:0] SLOT_ID    = IDX_W'(2);
    localparam logic [IDX_W-1:0] SLOT_LEN   = IDX_W'(3);
    localparam logic [IDX_W-1:0] SLOT_CMD   = IDX_W'(4);
    localparam logic [IDX_W-1:0] SLOT_PARAM = IDX_W'(5);

    // request beat
    typedef struct packed {
        logic [7:0] servo_addr;
        logic [7:0] frame_length;
        logic [7:0] command_code;
        logic [7:0] param_0;
        logic [7:0] param_1;
        logic [7:0] param_2;
        logic [7:0] param_3;
    } req_t;

    // frame byte beat
    typedef struct packed {
        logic [7:0] tx_byte;
        logic       last_byte;
        logic       bad_length;
    } beat_t;

    // classified request, as queued for the back end
    typedef struct packed {
        logic                             bad;
        logic [7:0]                       servo_addr;
        logic [7:0]                       frame_length;
        logic [7:0]                       command_code;
        logic [PARAM_INPUTS-1:0][7:0]     params;
        logic [7:0]                       checksum;
        logic [IDX_W-1:0]                 last_idx;
    } desc_t;

    // queue head as seen by the back end
    typedef struct packed {
        logic  valid;
        desc_t desc;
    } head_t;

endpackage

/* rtl/sbfb_front.sv */
// front end: length check and checksum of one request
module sbfb_front
    import sbfb_pkg::*;
#(
    parameter int MAX_PARAMS = MAX_PARAMS_DEF
) (
    input  req_t  req,
    output desc_t desc
);

    // parameter count is capped by the parameter inputs that exist
    localparam int EFF_MAX = (MAX_PARAMS > PARAM_INPUTS) ? PARAM_INPUTS : MAX_PARAMS;
    localparam logic [7:0] LEN_MIN = 8'(LEN_BASE);
    localparam logic [7:0] LEN_MAX = 8'(LEN_BASE + EFF_MAX);

    logic [PARAM_INPUTS-1:0][7:0] prm;
    logic                         bad;
    logic [7:0]                   np;

    assign prm = {req.param_3, req.param_2, req.param_1, req.param_0};
    assign bad = (req.frame_length < LEN_MIN) || (req.frame_length > LEN_MAX);
    assign np  = req.frame_length - LEN_MIN;

    // checksum over header fields and the parameters that are sent
    always_comb
    begin
        logic [7:0] sum;
        sum = req.servo_addr + req.frame_length + req.command_code;
        for (int i = 0; i < PARAM_INPUTS; i++)
        begin
            if (8'(i) < np)
            begin
                sum = sum + prm[i];
            end
        end
        desc.bad          = bad;
        desc.servo_addr   = req.servo_addr;
        desc.frame_length = req.frame_length;
        desc.command_code = req.command_code;
        desc.params       = prm;
        desc.checksum     = ~sum;
        // last byte index is length + 2, or 0 for the single error beat
        desc.last_idx     = bad ? '0 : IDX_W'(req.frame_length + 8'd2);
    end

endmodule

/* rtl/sbfb_queue.sv */
// short queue of classified requests between front and back
module sbfb_queue
    import sbfb_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  desc_t push_desc,
    output logic  full,
    input  logic  pop,
    output head_t head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

    desc_t             store_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head.valid = (count_reg != '0);
    assign head.desc  = store_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            store_reg[wr_ptr_reg] <= push_desc;
        end
    end

endmodule

/* rtl/sbfb_back.sv */
// back end: walks a queued request byte by byte into the output register
module sbfb_back
    import sbfb_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  head_t head,
    output logic  pop,
    output logic  frame_valid,
    input  logic  frame_stall,
    output beat_t frame
);

    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic              valid_reg, valid_next;
    beat_t             beat_reg, beat_next;
    logic              advance;
    logic              is_last;
    logic [PSEL_W-1:0] psel;
    logic [7:0]        byte_sel;

    assign frame_valid = valid_reg;
    assign frame       = beat_reg;

    // output register is free when empty or being taken
    assign advance = !valid_reg || !frame_stall;
    assign is_last = head.desc.bad || (idx_reg == head.desc.last_idx);
    assign pop     = advance && head.valid && is_last;
    assign psel    = PSEL_W'(idx_reg - SLOT_PARAM);

    // byte for the current slot
    always_comb
    begin
        case (idx_reg)
            SLOT_HDR0, SLOT_HDR1: byte_sel = HDR_BYTE;
            SLOT_ID:              byte_sel = head.desc.servo_addr;
            SLOT_LEN:             byte_sel = head.desc.frame_length;
            SLOT_CMD:             byte_sel = head.desc.command_code;
            default:
            begin
                if (idx_reg == head.desc.last_idx)
                begin
                    byte_sel = head.desc.checksum;
                end
                else
                begin
                    byte_sel = head.desc.params[psel];
                end
            end
        endcase
    end

    // next beat and slot counter
    always_comb
    begin
        idx_next   = idx_reg;
        valid_next = valid_reg;
        beat_next  = beat_reg;
        if (advance)
        begin
            valid_next = head.valid;
            if (head.valid)
            begin
                beat_next.tx_byte    = head.desc.bad ? 8'h00 : byte_sel;
                beat_next.last_byte  = is_last;
                beat_next.bad_length = head.desc.bad;
                idx_next             = is_last ? '0 : idx_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        beat_reg <= beat_next;
    end

endmodule

/* rtl/servo_bus_frame_builder.sv */
// top level of the servo bus frame builder
//
// Request channel (req_valid / req_stall / req) takes one servo command:
// id, length field, command code and four parameter bytes. Frame channel
// (frame_valid / frame_stall / frame) gives the serial frame one byte per
// beat: 0x55 0x55, id, length, command, length-3 parameters, checksum, the
// checksum beat marked with last_byte. A length outside 3..3+MAX_PARAMS
// (capped at four) gives one beat with tx_byte 0, last_byte and bad_length.
// A request reaches the output through the queue entry and the output
// register. The byte serializer in the back end gives one byte per cycle
// while frame_stall is low, length+3 bytes a request (one for an error);
// frames follow each other with no gap. A two-entry queue parts request
// intake from the serializer, so requests are taken while a frame is still
// sent. When frame_stall is high the output beat holds, the serializer waits
// and req_stall rises once the queue is full. Reset empties the queue and the
// output register; no bytes are pending afterwards.
module servo_bus_frame_builder
    import sbfb_pkg::*;
#(
    parameter int MAX_PARAMS = MAX_PARAMS_DEF
) (
    input  logic  clk,
    input  logic  rst_n,
    input  logic  req_valid,
    output logic  req_stall,
    input  req_t  req,
    output logic  frame_valid,
    input  logic  frame_stall,
    output beat_t frame
);

`include "servo_bus_frame_builder_assert.svh"

    desc_t front_desc;
    head_t head;
    logic  q_full;
    logic  q_pop;
    logic  q_push;

    assign req_stall = q_full;
    assign q_push    = req_valid && !q_full;

    // classification
    sbfb_front #(
        .MAX_PARAMS(MAX_PARAMS)
    ) u_front (
        .req  (req),
        .desc (front_desc)
    );

    // decoupling queue
    sbfb_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_desc (front_desc),
        .full      (q_full),
        .pop       (q_pop),
        .head      (head)
    );

    // byte serializer
    sbfb_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (head),
        .pop         (q_pop),
        .frame_valid (frame_valid),
        .frame_stall (frame_stall),
        .frame       (frame)
    );

    // checks
    `SBFB_ASSERT_NOW(a_bad_is_last, frame_valid && frame.bad_length, frame.last_byte && (frame.tx_byte == 8'h00), "error beat must be a lone zero byte")
    `SBFB_ASSERT_NEXT(a_frame_contiguous, frame_valid && !frame_stall && !frame.last_byte, frame_valid && !frame.bad_length, "gap or error inside a frame")
    `SBFB_ASSERT_NOW(a_pop_needs_entry, q_pop, head.valid && (!frame_valid || !frame_stall), "queue popped while empty or stalled")

endmodule

/* tb/sv/frame_byte_scoreboard_pkg.sv */
// scoreboard class that predicts and checks the frame bytes of the builder
`timescale 1ns / 1ps

package frame_byte_scoreboard_pkg;

    import sbfb_pkg::*;

    class frame_byte_scoreboard;

        beat_t pending_bytes[$];
        int    error_count;
        int    param_cap;

        function new(int max_params);
            error_count = 0;
            // only four parameter inputs exist, so larger settings act as four
            param_cap = (max_params > PARAM_INPUTS) ? PARAM_INPUTS : max_params;
        endfunction

        // queue one expected byte beat
        function void push_byte(logic [7:0] value, logic last, logic bad);
            beat_t b;
            b.tx_byte    = value;
            b.last_byte  = last;
            b.bad_length = bad;
            pending_bytes.push_back(b);
        endfunction

        // work out the whole frame for an accepted request
        function void note_request(req_t r);
            logic [7:0] sum;
            logic [7:0] params [PARAM_INPUTS];
            int         n_params;
            int         i;
            params[0] = r.param_0;
            params[1] = r.param_1;
            params[2] = r.param_2;
            params[3] = r.param_3;
            // length out of range: one error beat, no frame
            if (r.frame_length < LEN_BASE || r.frame_length > LEN_BASE + param_cap)
            begin
                push_byte(8'h00, 1'b1, 1'b1);
                return;
            end
            n_params = int'(r.frame_length) - LEN_BASE;
            sum = r.servo_addr + r.frame_length + r.command_code;
            push_byte(HDR_BYTE, 1'b0, 1'b0);
            push_byte(HDR_BYTE, 1'b0, 1'b0);
            push_byte(r.servo_addr, 1'b0, 1'b0);
            push_byte(r.frame_length, 1'b0, 1'b0);
            push_byte(r.command_code, 1'b0, 1'b0);
            // unused parameters stay out of the checksum
            for (i = 0; i < n_params; i++)
            begin
                sum = sum + params[i];
                push_byte(params[i], 1'b0, 1'b0);
            end
            push_byte(~sum, 1'b1, 1'b0);
        endfunction

        // compare an accepted byte beat with the oldest expectation
        function void check_beat(beat_t actual);
            beat_t wanted;
            if (pending_bytes.size() == 0)
            begin
                $error("unexpected beat: tx_byte %0h last_byte %0b bad_length %0b",
                       actual.tx_byte, actual.last_byte, actual.bad_length);
                error_count++;
                return;
            end
            wanted = pending_bytes.pop_front();
            if (actual.tx_byte !== wanted.tx_byte)
            begin
                $error("tx_byte: expected %0h, got %0h", wanted.tx_byte, actual.tx_byte);
                error_count++;
            end
            if (actual.last_byte !== wanted.last_byte)
            begin
                $error("last_byte: expected %0b, got %0b",
                       wanted.last_byte, actual.last_byte);
                error_count++;
            end
            if (actual.bad_length !== wanted.bad_length)
            begin
                $error("bad_length: expected %0b, got %0b",
                       wanted.bad_length, actual.bad_length);
                error_count++;
            end
        endfunction

        function int pending();
            return pending_bytes.size();
        endfunction

    endclass

endpackage

/* tb/sv/servo_bus_frame_builder_test.sv */
// top-level testbench of the servo bus frame builder
`timescale 1ns / 1ps

module servo_bus_frame_builder_test;

    import sbfb_pkg::*;
    import frame_byte_scoreboard_pkg::*;

    localparam int RANDOM_ITEMS = 280;
    localparam int HOLD_CYCLES  = 80;
    localparam int STUCK_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 20;

    logic  clk;
    logic  rst_n;
    logic  req_valid;
    logic  req_stall;
    req_t  req;
    logic  frame_valid;
    logic  frame_stall;
    beat_t frame;

    frame_byte_scoreboard sb;

    // shared controls of the idling pattern
    bit quiet;
    bit hold_request;
    int stuck_cycles;

    servo_bus_frame_builder #(
        .MAX_PARAMS(MAX_PARAMS_DEF)
    ) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .req        (req),
        .frame_valid(frame_valid),
        .frame_stall(frame_stall),
        .frame      (frame)
    );

    // clock
    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic req_t make_req(logic [7:0] id, logic [7:0] len, logic [7:0] cmd,
                                      logic [7:0] p0, logic [7:0] p1,
                                      logic [7:0] p2, logic [7:0] p3);
        req_t r;
        r.servo_addr   = id;
        r.frame_length = len;
        r.command_code = cmd;
        r.param_0      = p0;
        r.param_1      = p1;
        r.param_2      = p2;
        r.param_3      = p3;
        return r;
    endfunction

    function automatic req_t random_req();
        req_t        r;
        int unsigned pick;
        r = make_req(8'($urandom_range(255)), 8'h00, 8'($urandom_range(255)),
                     8'($urandom_range(255)), 8'($urandom_range(255)),
                     8'($urandom_range(255)), 8'($urandom_range(255)));
        pick = $urandom_range(99);
        // mostly well-formed lengths, some near the edges, some anywhere
        if (pick < 85)
            r.frame_length = 8'(LEN_BASE + $urandom_range(MAX_PARAMS_DEF));
        else if (pick < 93)
            r.frame_length = ($urandom_range(1) == 0) ? 8'($urandom_range(LEN_BASE - 1))
                                                       : 8'(LEN_BASE + MAX_PARAMS_DEF + 1);
        else
            r.frame_length = 8'($urandom_range(255));
        if ($urandom_range(9) == 0)
            r.servo_addr = 8'hFE;
        return r;
    endfunction

    // offer one request beat and wait until it is taken
    task automatic send_request(req_t r);
        int gap;
        if (!quiet && $urandom_range(99) < 8)
        begin
            gap = $urandom_range(6, 1);
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= r;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
    endtask

    // stop offering until every expected byte has come
    task automatic drain_frames();
        req_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    // receiver: random stalls and one long hold-off
    initial
    begin
        frame_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                frame_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                frame_stall <= 1'b0;
            end
            else
            begin
                frame_stall <= !quiet && ($urandom_range(99) < 8);
            end
        end
    end

    // monitor of both channels
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (frame_valid && !frame_stall)
                sb.check_beat(frame);
            if (req_valid && !req_stall)
                sb.note_request(req);
            if ((frame_valid && !frame_stall) || (req_valid && !req_stall))
                stuck_cycles <= 0;
            else
                stuck_cycles <= stuck_cycles + 1;
        end
    end

    // watchdog
    initial
    begin
        wait (stuck_cycles >= STUCK_LIMIT);
        $display("Verification failed");
        $finish;
    end

    // stimulus
    initial
    begin
        sb           = new(MAX_PARAMS_DEF);
        quiet        = 1'b0;
        hold_request = 1'b0;
        stuck_cycles = 0;
        rst_n        = 1'b0;
        req_valid    = 1'b0;
        req          = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // every length from empty to one past the largest, and the bad edges
        send_request(make_req(8'h01, 8'd0, 8'h01, 8'h11, 8'h22, 8'h33, 8'h44));
        send_request(make_req(8'h02, 8'd1, 8'h02, 8'h11, 8'h22, 8'h33, 8'h44));
        send_request(make_req(8'h03, 8'd2, 8'h03, 8'h11, 8'h22, 8'h33, 8'h44));
        send_request(make_req(8'h04, 8'd3, 8'h04, 8'h11, 8'h22, 8'h33, 8'h44));
        send_request(make_req(8'h05, 8'd4, 8'h05, 8'h11, 8'h22, 8'h33, 8'h44));
        send_request(make_req(8'h06, 8'd5, 8'h06, 8'h11, 8'h22, 8'h33, 8'h44));
        send_request(make_req(8'h07, 8'd6, 8'h07, 8'h11, 8'h22, 8'h33, 8'h44));
        send_request(make_req(8'h08, 8'd7, 8'h08, 8'h11, 8'h22, 8'h33, 8'h44));
        send_request(make_req(8'h09, 8'd8, 8'h09, 8'h11, 8'h22, 8'h33, 8'h44));
        send_request(make_req(8'h0A, 8'd255, 8'h0A, 8'h11, 8'h22, 8'h33, 8'h44));
        send_request(make_req(8'hFF, 8'd128, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
        // field extremes, broadcast id and checksum wrap
        send_request(make_req(8'h00, 8'd3, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
        send_request(make_req(8'hFF, 8'd7, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
        send_request(make_req(8'hFE, 8'd7, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
        send_request(make_req(8'hFE, 8'd3, 8'hFF, 8'hAA, 8'h55, 8'hAA, 8'h55));
        send_request(make_req(8'hFC, 8'd4, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
        // unused parameters set, must not reach the frame or the checksum
        send_request(make_req(8'h10, 8'd4, 8'h1E, 8'h80, 8'hFF, 8'hFF, 8'hFF));
        send_request(make_req(8'h20, 8'd5, 8'h1F, 8'h7F, 8'h01, 8'hFF, 8'hFF));
        send_request(make_req(8'h30, 8'd6, 8'h20, 8'h00, 8'hFF, 8'h00, 8'hFF));
        send_request(make_req(8'hA5, 8'd7, 8'h5A, 8'hC3, 8'h3C, 8'h0F, 8'hF0));
        drain_frames();

        // random requests with one drain pause, one long hold-off and a quiet stretch
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i == 60)
                drain_frames();
            if (i == 120)
                hold_request = 1'b1;
            quiet = (i >= 160 && i < 230);
            send_request(random_req());
        end
        req_valid <= 1'b0;
        quiet = 1'b0;

        // wait for the last frames, then a few more cycles for strays
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.error_count == 0 && sb.pending() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

/* sim.f */
+incdir+rtl
rtl/sbfb_pkg.sv
rtl/sbfb_front.sv
rtl/sbfb_queue.sv
rtl/sbfb_back.sv
rtl/servo_bus_frame_builder.sv
tb/sv/frame_byte_scoreboard_pkg.sv
tb/sv/servo_bus_frame_builder_test.sv
